FILE: rtl/core/icer_pkg.sv
package icer_pkg;

  // Byte counter saturates here; later bytes of an oversize packet are ignored.
  localparam logic [15:0] MaxPacketBytes = 16'd65535;

  // Extra bytes past the IP header that a reply must carry (ICMP header).
  localparam logic [15:0] IcmpHdrBytes = 16'd8;

  // Reset value of the minimum round-trip time.
  localparam logic [31:0] MinTimeReset = 32'h0000_FFFF;

  // Folded ones' complement sum of a good packet.
  localparam logic [15:0] SumAllOnes = 16'hFFFF;

  // Result status codes, in priority order after ok.
  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StTooShort = 3'd1,
    StBadSum   = 3'd2,
    StNotReply = 3'd3,
    StBadId    = 3'd4
  } status_e;

  // One received byte with its sideband.
  typedef struct packed {
    logic [7:0]  packet_byte;
    logic        last_byte;
    logic [31:0] now_ms;
  } in_item_t;

  // One reported packet result.
  typedef struct packed {
    status_e     status;
    logic [7:0]  msg_type;
    logic [15:0] payload_len;
    logic [15:0] sequence_res;
    logic [31:0] round_trip_ms;
    logic [31:0] received_count;
    logic [31:0] min_ms;
    logic [31:0] max_ms;
    logic [31:0] total_ms;
  } out_item_t;

  // Packet summary handed from the byte parser to the checker.
  typedef struct packed {
    logic [15:0] rx_len;
    logic [5:0]  hdr_bytes;
    logic [15:0] ip_len;
    logic [31:0] sum;
    logic [7:0]  msg_type;
    logic [15:0] ident;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [31:0] now_ms;
  } pkt_sum_t;

  // Check verdict handed from the checker to the statistics stage.
  typedef struct packed {
    status_e     status;
    logic [7:0]  msg_type;
    logic [15:0] payload_len;
    logic [15:0] seq;
    logic [31:0] trip;
  } chk_res_t;

endpackage

FILE: rtl/core/icer_parse.sv
module icer_parse import icer_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_valid_i,
  input  in_item_t item_i,
  output logic     item_ready_o,
  output logic     sum_valid_o,
  output pkt_sum_t sum_o,
  input  logic     sum_ready_i
);

  // Input register.
  logic     s1_valid_q;
  in_item_t s1_item_q;

  // Per-packet state.
  logic [15:0] idx_q, idx_d;
  logic [5:0]  hdr_q, hdr_d;
  logic [15:0] tot_q, tot_d;
  logic [31:0] sum_q, sum_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  head_q, head_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] ident_q, ident_d;
  logic [15:0] seq_q, seq_d;
  logic [31:0] stamp_q, stamp_d;

  // Summary register.
  logic     fin_valid_q;
  pkt_sum_t fin_q;

  logic        fin_ready;
  logic        s1_ready;
  logic        s1_fire;
  logic        active;
  logic [7:0]  b;
  logic        in_icmp;
  logic [15:0] off;
  logic [15:0] add_a;
  logic [15:0] add_b;

  // A byte that ends a packet needs room in the summary register.
  assign fin_ready    = !fin_valid_q || sum_ready_i;
  assign s1_ready     = !s1_item_q.last_byte || fin_ready;
  assign s1_fire      = s1_valid_q && s1_ready;
  assign item_ready_o = !s1_valid_q || s1_ready;

  assign b      = s1_item_q.packet_byte;
  assign active = idx_q != MaxPacketBytes;

  // Header fields, capture and checksum for the byte in the input register.
  always_comb begin
    hdr_d   = hdr_q;
    tot_d   = tot_q;
    low_d   = low_q;
    head_d  = head_q;
    type_d  = type_q;
    ident_d = ident_q;
    seq_d   = seq_q;
    stamp_d = stamp_q;
    idx_d   = idx_q;
    add_a   = '0;
    add_b   = '0;
    in_icmp = 1'b0;
    off     = '0;
    if (active) begin
      if (idx_q == 16'd0) begin
        hdr_d  = {b[3:0], 2'b00};
        head_d = b;
      end else if (idx_q == 16'd1) begin
        low_d = b;
      end else if (idx_q == 16'd2) begin
        tot_d = {b, 8'h00};
      end else if (idx_q == 16'd3) begin
        tot_d = {tot_q[15:8], b};
      end
      in_icmp = idx_q >= {10'b0, hdr_d};
      off     = idx_q - {10'b0, hdr_d};
      if (in_icmp && (off[15:4] == 12'd0)) begin
        case (off[3:0])
          4'd0:    type_d = b;
          4'd4:    ident_d = {ident_q[15:8], b};
          4'd5:    ident_d = {b, ident_q[7:0]};
          4'd6:    seq_d = {seq_q[15:8], b};
          4'd7:    seq_d = {b, seq_q[7:0]};
          4'd8:    stamp_d = {stamp_q[31:8], b};
          4'd9:    stamp_d = {stamp_q[31:16], b, stamp_q[7:0]};
          4'd10:   stamp_d = {stamp_q[31:24], b, stamp_q[15:0]};
          4'd11:   stamp_d = {b, stamp_q[23:0]};
          default: ;
        endcase
      end
      // With a zero header length the first four bytes are summed at byte three.
      if (in_icmp) begin
        if (idx_q >= 16'd4) begin
          if (idx_q < tot_d) begin
            add_a = idx_q[0] ? {8'h00, b} : {b, 8'h00};
          end
        end else if (idx_q == 16'd3) begin
          add_a = {(tot_d > 16'd0) ? head_q : 8'h00, (tot_d > 16'd1) ? low_q : 8'h00};
          add_b = {(tot_d > 16'd2) ? tot_d[15:8] : 8'h00, (tot_d > 16'd3) ? b : 8'h00};
        end
      end
      idx_d = idx_q + 16'd1;
    end
    sum_d = sum_q + {16'b0, add_a} + {16'b0, add_b};
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_ready_o) begin
      s1_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i && item_ready_o) begin
      s1_item_q <= item_i;
    end
  end

  // Packet state: updated per byte, cleared after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      hdr_q   <= '0;
      tot_q   <= '0;
      sum_q   <= '0;
      low_q   <= '0;
      head_q  <= '0;
      type_q  <= '0;
      ident_q <= '0;
      seq_q   <= '0;
      stamp_q <= '0;
    end else if (s1_fire) begin
      if (s1_item_q.last_byte) begin
        idx_q   <= '0;
        hdr_q   <= '0;
        tot_q   <= '0;
        sum_q   <= '0;
        low_q   <= '0;
        head_q  <= '0;
        type_q  <= '0;
        ident_q <= '0;
        seq_q   <= '0;
        stamp_q <= '0;
      end else begin
        idx_q   <= idx_d;
        hdr_q   <= hdr_d;
        tot_q   <= tot_d;
        sum_q   <= sum_d;
        low_q   <= low_d;
        head_q  <= head_d;
        type_q  <= type_d;
        ident_q <= ident_d;
        seq_q   <= seq_d;
        stamp_q <= stamp_d;
      end
    end
  end

  // Summary register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (fin_ready) begin
      fin_valid_q <= s1_fire && s1_item_q.last_byte;
    end
  end

  // Summary of a finished packet, taken from the updated state.
  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_item_q.last_byte) begin
      fin_q.rx_len    <= idx_d;
      fin_q.hdr_bytes <= hdr_d;
      fin_q.ip_len    <= tot_d;
      fin_q.sum       <= sum_d;
      fin_q.msg_type  <= type_d;
      fin_q.ident     <= ident_d;
      fin_q.seq       <= seq_d;
      fin_q.stamp     <= stamp_d;
      fin_q.now_ms    <= s1_item_q.now_ms;
    end
  end

  assign sum_valid_o = fin_valid_q;
  assign sum_o       = fin_q;

endmodule

FILE: rtl/core/icer_check.sv
module icer_check import icer_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] expected_id_i,
  input  logic        sum_valid_i,
  input  pkt_sum_t    sum_i,
  output logic        sum_ready_o,
  output logic        res_valid_o,
  output chk_res_t    res_o,
  input  logic        res_ready_i
);

  logic     valid_q;
  chk_res_t res_q;
  chk_res_t res_d;

  logic [16:0] fold1;
  logic [15:0] fold2;
  logic        too_short;

  assign sum_ready_o = !valid_q || res_ready_i;

  // Fold the checksum, then rank the failures.
  always_comb begin
    fold1     = {1'b0, sum_i.sum[31:16]} + {1'b0, sum_i.sum[15:0]};
    fold2     = fold1[15:0] + {15'b0, fold1[16]};
    too_short = ({1'b0, sum_i.rx_len} < ({11'b0, sum_i.hdr_bytes} + {1'b0, IcmpHdrBytes}))
             || (sum_i.rx_len < sum_i.ip_len);
    if (too_short) begin
      res_d.status = StTooShort;
    end else if (fold2 != SumAllOnes) begin
      res_d.status = StBadSum;
    end else if (sum_i.msg_type != 8'd0) begin
      res_d.status = StNotReply;
    end else if (sum_i.ident != expected_id_i) begin
      res_d.status = StBadId;
    end else begin
      res_d.status = StOk;
    end
    res_d.msg_type    = sum_i.msg_type;
    res_d.payload_len = sum_i.ip_len - {10'b0, sum_i.hdr_bytes} - IcmpHdrBytes;
    res_d.seq         = sum_i.seq;
    res_d.trip        = sum_i.now_ms - sum_i.stamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sum_ready_o) begin
      valid_q <= sum_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_valid_i && sum_ready_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/core/icer_stats.sv
module icer_stats import icer_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_valid_i,
  input  chk_res_t  res_i,
  output logic      res_ready_o,
  output logic      out_valid_o,
  output out_item_t out_o,
  input  logic      out_ready_i
);

  logic        valid_q;
  out_item_t   out_q;
  logic [31:0] count_q, count_d;
  logic [31:0] total_q, total_d;
  logic [31:0] min_q, min_d;
  logic [31:0] max_q, max_d;
  logic        fire;

  assign res_ready_o = !valid_q || out_ready_i;
  assign fire        = res_valid_i && res_ready_o;

  // Running statistics over good replies.
  always_comb begin
    count_d = count_q;
    total_d = total_q;
    min_d   = min_q;
    max_d   = max_q;
    if (res_i.status == StOk) begin
      count_d = count_q + 32'd1;
      total_d = total_q + res_i.trip;
      if (min_q > res_i.trip) begin
        min_d = res_i.trip;
      end
      if (max_q < res_i.trip) begin
        max_d = res_i.trip;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      count_q <= '0;
      total_q <= '0;
      min_q   <= MinTimeReset;
      max_q   <= '0;
    end else begin
      if (res_ready_o) begin
        valid_q <= res_valid_i;
      end
      if (fire) begin
        count_q <= count_d;
        total_q <= total_d;
        min_q   <= min_d;
        max_q   <= max_d;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.status         <= res_i.status;
      out_q.msg_type       <= res_i.msg_type;
      out_q.payload_len    <= res_i.payload_len;
      out_q.sequence_res   <= res_i.seq;
      out_q.round_trip_ms  <= res_i.trip;
      out_q.received_count <= count_d;
      out_q.min_ms         <= min_d;
      out_q.max_ms         <= max_d;
      out_q.total_ms       <= total_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;

endmodule

FILE: rtl/core/icmp_echo_reply_checker.sv
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+----------------------------------
// in       | input     | in_valid_i / in_stall_o   | in_item_t: byte, last mark, time
// out      | output    | out_valid_o / out_stall_i | out_item_t: status and statistics
// cfg      | input     | cfg_valid_i / cfg_ready_o | expected identifier, 16 bits
//
// One byte is taken every cycle while no last byte waits for room; the per-byte state update
// adds into the checksum accumulator. Once a packet's last byte is transferred, its result
// passes through the summary, check and output registers behind the input register.
// Reset is asynchronous: it clears the packet state, the statistics (minimum to
// 65535) and the expected identifier. A stalled output holds its result; ordinary
// bytes keep flowing, and only a last byte waits for room in the result stages.
module icmp_echo_reply_checker import icer_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  in_item_t    in_data_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  output out_item_t   out_data_o,
  input  logic        out_stall_i,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  output logic        cfg_ready_o
);

  logic [15:0] expected_id_q;
  logic        in_ready;
  logic        sum_valid;
  pkt_sum_t    sum;
  logic        sum_ready;
  logic        res_valid;
  chk_res_t    res;
  logic        res_ready;

  // Configuration register: every transfer is taken at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      expected_id_q <= cfg_data_i;
    end
  end

  assign in_stall_o = !in_ready;

  icer_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_i),
    .item_i       (in_data_i),
    .item_ready_o (in_ready),
    .sum_valid_o  (sum_valid),
    .sum_o        (sum),
    .sum_ready_i  (sum_ready)
  );

  icer_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .expected_id_i (expected_id_q),
    .sum_valid_i   (sum_valid),
    .sum_i         (sum),
    .sum_ready_o   (sum_ready),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready)
  );

  icer_stats u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (out_valid_o),
    .out_o       (out_data_o),
    .out_ready_i (!out_stall_i)
  );

endmodule
